// ===== hdl/oew_pkg.sv =====
// Package for the optimal extraction weights core.
// Holds shared types and constants; depends on nothing.
`timescale 1ns / 1ps
package oew_pkg;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam int SUM_W = 48;

    typedef struct packed {
        logic        col_end;
        logic        store;
        logic [31:0] model;
        logic [31:0] ivar;
    } oew_cmd_t;
endpackage

// ===== hdl/oew_front.sv =====
// Front part: accepts pixels, marks those beyond the row capacity for
// skipping, and puts all in a two-entry queue. Depends on oew_pkg.
`timescale 1ns / 1ps
module oew_front
    import oew_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int CNT_W = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_model,
    input  logic [31:0] s_ivar,
    input  logic        s_last,
    output logic        q_valid,
    input  logic        q_ready,
    output oew_cmd_t    q_cmd
);
    oew_cmd_t        q_mem [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic [CNT_W-1:0] rows_reg;
    logic            push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = q_mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg].col_end <= s_last;
            q_mem[wp_reg].store   <= (rows_reg < CNT_W'(MAX_ROWS));
            q_mem[wp_reg].model   <= s_model;
            q_mem[wp_reg].ivar    <= s_ivar;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            cnt_reg  <= 2'd0;
            rows_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
                if (s_last)
                    rows_reg <= '0;
                else if (rows_reg < CNT_W'(MAX_ROWS))
                    rows_reg <= rows_reg + 1'b1;
            end
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== hdl/oew_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on nothing.
`timescale 1ns / 1ps
module oew_div #(
    parameter int NW = 64,
    parameter int DW = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [CW-1:0] n_reg;
    logic [DW-1:0] d_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   trial;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};
    assign quo   = q_reg;
    assign done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                n_reg    <= CW'(NW);
            end
            else if (busy_reg)
            begin
                n_reg <= n_reg - 1'b1;
                if (n_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== hdl/oew_back.sv =====
// Back part: buffers the column, sums it, and on the column end runs the
// profile and weight passes with a shared divider. Depends on oew_pkg, oew_div.
`timescale 1ns / 1ps
module oew_back
    import oew_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int AW = 6,
    parameter int CNT_W = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  oew_cmd_t    q_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_prof,
    output logic [31:0] m_weight,
    output logic        m_last
);
    typedef enum logic [3:0] {
        ST_COLLECT, ST_P_RD, ST_P_DIV, ST_P_WAIT, ST_P_SQ, ST_P_TERM,
        ST_W_RD, ST_W_MUL, ST_W_DIV, ST_W_WAIT, ST_OUT
    } state_t;

    state_t            state_reg;
    logic [31:0]       model_mem [MAX_ROWS];
    logic [31:0]       ivar_mem  [MAX_ROWS];
    logic [31:0]       prof_mem  [MAX_ROWS];
    logic [31:0]       rd_model_reg, rd_ivar_reg, rd_prof_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]  n_reg, r_reg;
    logic [63:0]       norm_reg;
    logic [63:0]       sq_reg, prod_reg;
    logic              neg_reg, pos_reg;
    logic [31:0]       prof_reg;
    logic              div_start;
    logic [63:0]       div_num, div_den, div_q;
    logic              div_done;
    logic [AW-1:0]     ra;
    logic [63:0]       absnum, sq_full;
    logic signed [63:0] sq_in;

    assign ra = r_reg[AW-1:0];
    assign q_ready = (state_reg == ST_COLLECT);

    oew_div #(.NW(64), .DW(64)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quo(div_q)
    );

    assign absnum = rd_model_reg[31] ? {16'd0, (~rd_model_reg) + 32'd1, 16'd0}
                                     : {16'd0, rd_model_reg, 16'd0};
    assign div_start = (state_reg == ST_P_DIV) || (state_reg == ST_W_DIV);
    assign div_num = (state_reg == ST_P_DIV) ? absnum : prod_reg;
    assign div_den = (state_reg == ST_P_DIV) ? 64'(sum_reg) : norm_reg;
    assign sq_in = 64'(signed'(prof_reg));
    assign sq_full = 64'(sq_in * sq_in);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COLLECT && q_valid && q_cmd.store)
        begin
            model_mem[n_reg[AW-1:0]] <= q_cmd.model;
            ivar_mem[n_reg[AW-1:0]]  <= q_cmd.ivar;
        end
        if (state_reg == ST_P_TERM)
            prof_mem[ra] <= prof_reg;
        rd_model_reg <= model_mem[ra];
        rd_ivar_reg  <= ivar_mem[ra];
        rd_prof_reg  <= prof_mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            sum_reg   <= '0;
            n_reg     <= '0;
            r_reg     <= '0;
            norm_reg  <= '0;
            m_valid   <= 1'b0;
            m_last    <= 1'b0;
            m_prof    <= '0;
            m_weight  <= '0;
            sq_reg    <= '0;
            prod_reg  <= '0;
            neg_reg   <= 1'b0;
            pos_reg   <= 1'b0;
            prof_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_COLLECT:
                begin
                    if (q_valid)
                    begin
                        if (q_cmd.store)
                        begin
                            n_reg   <= n_reg + 1'b1;
                            sum_reg <= sum_reg + SUM_W'(signed'(q_cmd.model));
                        end
                        if (q_cmd.col_end)
                        begin
                            r_reg    <= '0;
                            norm_reg <= '0;
                            state_reg <= ST_P_RD;
                        end
                    end
                end
                ST_P_RD:
                begin
                    if (r_reg == n_reg || sum_reg <= 0)
                    begin
                        r_reg     <= '0;
                        state_reg <= ST_W_RD;
                    end
                    else
                        state_reg <= ST_P_DIV;
                end
                ST_P_DIV:
                begin
                    neg_reg <= rd_model_reg[31];
                    state_reg <= ST_P_WAIT;
                end
                ST_P_WAIT:
                begin
                    if (div_done)
                    begin
                        if (neg_reg)
                            prof_reg <= (div_q > 64'h8000_0000) ? 32'h8000_0000
                                        : 32'((~div_q) + 64'd1);
                        else
                            prof_reg <= (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                        : div_q[31:0];
                        state_reg <= ST_P_SQ;
                    end
                end
                ST_P_SQ:
                begin
                    sq_reg <= (sq_full[63:16] > 48'hFFFF_FFFF) ? 64'hFFFF_FFFF
                              : {32'd0, sq_full[47:16]};
                    state_reg <= ST_P_TERM;
                end
                ST_P_TERM:
                begin
                    norm_reg  <= norm_reg
                                 + (({32'd0, sq_reg[31:0]} * {32'd0, rd_ivar_reg}) >> 16);
                    r_reg     <= r_reg + 1'b1;
                    state_reg <= ST_P_RD;
                end
                ST_W_RD:
                begin
                    state_reg <= ST_W_MUL;
                end
                ST_W_MUL:
                begin
                    pos_reg  <= !rd_prof_reg[31] && (rd_prof_reg != 32'd0)
                                && (norm_reg != 64'd0) && (sum_reg > 0);
                    prod_reg <= {32'd0, rd_prof_reg} * {32'd0, rd_ivar_reg};
                    state_reg <= ST_W_DIV;
                end
                ST_W_DIV:
                begin
                    if (sum_reg <= 0)
                    begin
                        m_prof    <= rd_model_reg;
                        m_weight  <= Q_ONE;
                        m_last    <= (r_reg + 1'b1 == n_reg);
                        m_valid   <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                        state_reg <= ST_W_WAIT;
                end
                ST_W_WAIT:
                begin
                    if (div_done)
                    begin
                        m_prof   <= rd_prof_reg;
                        m_weight <= !pos_reg ? 32'd0
                                  : (div_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_q[31:0];
                        m_last   <= (r_reg + 1'b1 == n_reg);
                        m_valid  <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_ready)
                    begin
                        m_valid <= 1'b0;
                        if (m_last)
                        begin
                            n_reg     <= '0;
                            sum_reg   <= '0;
                            state_reg <= ST_COLLECT;
                        end
                        else
                        begin
                            r_reg     <= r_reg + 1'b1;
                            state_reg <= ST_W_RD;
                        end
                    end
                end
                default:
                    state_reg <= ST_COLLECT;
            endcase
        end
    end
endmodule

// ===== hdl/optimal_extraction_weights_core.sv =====
// Channel  Direction  Payload
// s_axis   in         model_value, inv_variance, column_end
// m_axis   out        profile_norm, pixel_weight, row_last
// A column is taken in first, then run through a profile pass and a weight
// pass over its rows; both passes share one bit-serial 64-bit divider. Reset
// is asynchronous and active low. A stalled output holds the back part; the
// front queue keeps taking pixels until its two entries are full.
`timescale 1ns / 1ps
module optimal_extraction_weights_core
    import oew_pkg::*;
#(
    parameter int MAX_ROWS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // model_value[31:0], inv_variance[63:32]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // profile_norm[31:0], pixel_weight[63:32]
    output logic        m_axis_tlast
);
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CNT_W = AW + 1;

    logic     q_valid, q_ready;
    oew_cmd_t q_cmd;
    logic [31:0] prof, weight;

    oew_front #(.MAX_ROWS(MAX_ROWS), .CNT_W(CNT_W)) u_front (
        .clk(clk), .rst_n(rst_n), .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .s_model(s_axis_tdata[31:0]), .s_ivar(s_axis_tdata[63:32]),
        .s_last(s_axis_tlast), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    oew_back #(.MAX_ROWS(MAX_ROWS), .AW(AW), .CNT_W(CNT_W)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_prof(prof),
        .m_weight(weight), .m_last(m_axis_tlast)
    );

    assign m_axis_tdata = {weight, prof};

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !q_ready)
        else $error("queue drained while emitting");
`endif
endmodule

// ===== tb/sv/optimal_extraction_weights_checker.sv =====
// Checker for the optimal extraction weights core.
// Watches both stream channels, predicts each column's rows and compares them.
// Depends on the block's port layout only.
`timescale 1ns / 1ps
module optimal_extraction_weights_checker
#(
    parameter int MAX_ROWS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [31:0] profile;
        logic [31:0] weight;
        logic        last;
    } row_result_t;

    logic [31:0]  col_model [MAX_ROWS];
    logic [31:0]  col_ivar [MAX_ROWS];
    int           col_rows;
    longint       col_sum;
    row_result_t  expected_rows [$];

    assign pending = expected_rows.size();

    task automatic add_pixel(input logic [31:0] mv, input logic [31:0] iv, input logic last);
        longint          prof [MAX_ROWS];
        longint          num;
        longint unsigned sq;
        longint unsigned norm;
        longint unsigned w;
        row_result_t     res;
        if (col_rows < MAX_ROWS)
        begin
            col_model[col_rows] = mv;
            col_ivar[col_rows] = iv;
            col_sum += longint'(signed'(mv));
            col_rows++;
        end
        if (!last)
            return;
        norm = 0;
        if (col_sum > 0)
        begin
            for (int r = 0; r < col_rows; r++)
            begin
                num = longint'(signed'(col_model[r])) * 65536;
                prof[r] = num / col_sum;
                if (prof[r] > 64'sd2147483647)
                    prof[r] = 64'sd2147483647;
                if (prof[r] < -64'sd2147483648)
                    prof[r] = -64'sd2147483648;
                sq = longint'(prof[r] * prof[r]) >> 16;
                if (sq > 64'hFFFF_FFFF)
                    sq = 64'hFFFF_FFFF;
                norm += (sq * longint'(col_ivar[r])) >> 16;
            end
            for (int r = 0; r < col_rows; r++)
            begin
                w = 0;
                if (prof[r] > 0 && norm != 0)
                begin
                    w = (longint'(prof[r]) * longint'(col_ivar[r])) / norm;
                    if (w > 64'hFFFF_FFFF)
                        w = 64'hFFFF_FFFF;
                end
                res.profile = prof[r][31:0];
                res.weight = w[31:0];
                res.last = (r + 1 == col_rows);
                expected_rows.push_back(res);
            end
        end
        else
        begin
            for (int r = 0; r < col_rows; r++)
            begin
                res.profile = col_model[r];
                res.weight = 32'h0001_0000;
                res.last = (r + 1 == col_rows);
                expected_rows.push_back(res);
            end
        end
        col_rows = 0;
        col_sum = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        row_result_t exp_row;
        if (!rst_n)
        begin
            errors <= 0;
            col_rows = 0;
            col_sum = 0;
            expected_rows.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                add_pixel(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_rows.size() == 0)
                begin
                    if (errors < 10)
                        $display("Unexpected row result: data %h last %b",
                                 m_axis_tdata, m_axis_tlast);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_row = expected_rows.pop_front();
                    if (exp_row.profile !== m_axis_tdata[31:0] ||
                        exp_row.weight !== m_axis_tdata[63:32] ||
                        exp_row.last !== m_axis_tlast)
                    begin
                        if (errors < 10)
                            $display("Row mismatch: expected profile %h weight %h last %b, got profile %h weight %h last %b",
                                     exp_row.profile, exp_row.weight, exp_row.last,
                                     m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/optimal_extraction_weights_core_tb.sv =====
// Top of the optimal extraction weights testbench.
// Drives columns of pixels into the core and gives the verdict; the checker
// module does all prediction and comparison.
`timescale 1ns / 1ps
module optimal_extraction_weights_core_tb;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          errors;
    int          pending;
    int          pixels_sent;
    bit          send_gaps;
    bit          recv_stalls;
    bit          hold_off;

    optimal_extraction_weights_core #(.MAX_ROWS(64)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    optimal_extraction_weights_checker #(.MAX_ROWS(64)) u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .errors(errors),
        .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic push_pixel(input logic [31:0] mv, input logic [31:0] iv, input logic last);
        int gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        repeat (gap)
        begin
            @(posedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {iv, mv};
        s_axis_tlast <= last;
        do
            @(negedge clk);
        while (!s_axis_tready);
        pixels_sent++;
    endtask

    task automatic push_random_column(input int rows);
        int          kind;
        logic [31:0] mv;
        logic [31:0] iv;
        kind = $urandom_range(0, 5);
        for (int r = 0; r < rows; r++)
        begin
            case (kind)
                0, 1, 2: mv = $urandom_range(0, 32'h0020_0000);
                3: mv = $urandom;
                4: mv = -$urandom_range(0, 32'h0020_0000);
                default: mv = ($urandom_range(0, 3) == 0) ? -$urandom_range(0, 32'h8000)
                                                          : $urandom_range(0, 32'h0008_0000);
            endcase
            case ($urandom_range(0, 4))
                0, 1: iv = $urandom;
                2: iv = 32'h0;
                default: iv = $urandom_range(0, 32'h0004_0000);
            endcase
            push_pixel(mv, iv, r == rows - 1);
        end
    endtask

    initial
    begin
        int recv_gap;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_off)
            begin
                @(posedge clk);
                m_axis_tready <= 1'b0;
                repeat (3000)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            recv_gap = recv_stalls ? $urandom_range(0, 9) : 0;
            repeat (recv_gap)
            begin
                @(posedge clk);
                m_axis_tready <= 1'b0;
            end
            @(posedge clk);
            m_axis_tready <= 1'b1;
            do
                @(negedge clk);
            while (!m_axis_tvalid && !hold_off);
        end
    end

    initial
    begin
        int rows;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        hold_off = 1'b0;
        pixels_sent = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        push_pixel(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_pixel(32'h8000_0000, 32'h0001_0000, 1'b0);
        push_pixel(32'h0000_0005, 32'h0000_0000, 1'b1);
        push_pixel(32'h0064_0000, 32'h0001_0000, 1'b0);
        push_pixel(32'hFFFF_0000, 32'h0002_0000, 1'b0);
        push_pixel(32'h0000_0000, 32'h0003_0000, 1'b1);
        push_pixel(32'h0010_0000, 32'h0000_0000, 1'b0);
        push_pixel(32'h0020_0000, 32'h0000_0000, 1'b1);
        push_pixel(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        push_pixel(32'h8000_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_pixel(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        push_pixel(32'h0000_0000, 32'h0000_0000, 1'b1);
        push_pixel(32'h0000_0000, 32'h1234_5678, 1'b1);
        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);

        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        hold_off = 1'b1;
        push_random_column(6);
        push_random_column(6);
        push_random_column(3);
        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);

        push_random_column(67);
        while (pixels_sent < 105)
        begin
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            rows = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 20)
                                                : $urandom_range(1, 6);
            push_random_column(rows);
            if ($urandom_range(0, 7) == 0)
            begin
                @(posedge clk);
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
                wait (pending == 0);
            end
        end
        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (300)
            @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== optimal_extraction_weights_core.f =====
hdl/oew_pkg.sv
hdl/oew_front.sv
hdl/oew_div.sv
hdl/oew_back.sv
hdl/optimal_extraction_weights_core.sv
tb/sv/optimal_extraction_weights_checker.sv
tb/sv/optimal_extraction_weights_core_tb.sv
